// File: src/mec_pkg.sv
// Shared types, constants and helper functions for the escape-count core.
// Depends on nothing; every other file in src imports it.
package mec_pkg;

  localparam int ZW          = 32;
  localparam int MAG_WIDTH   = 34;
  localparam int NR_W        = MAG_WIDTH + 2;
  localparam int MAXIT_WIDTH = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 34;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [MAXIT_WIDTH-1:0] MAXIT_RESET = MAXIT_WIDTH'(128);
  localparam logic [63:0] MAG_MAX = (64'd1 << MAG_WIDTH) - 64'd1;

  localparam logic signed [63:0] ZMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] ZMIN64 = -64'sd2147483648;

  // One queued point with its capped iteration limit.
  typedef struct packed {
    logic signed [ZW-1:0]    c_real;
    logic signed [ZW-1:0]    c_imag;
    logic [MAXIT_WIDTH-1:0]  limit;
    logic                    trivial;
  } entry_t;

  // Clamp a wide signed value to the signed range of z.
  function automatic logic signed [ZW-1:0] sat_z(input logic signed [63:0] v);
    logic signed [ZW-1:0] r;
    if (v > ZMAX64) begin
      r = ZMAX64[ZW-1:0];
    end else if (v < ZMIN64) begin
      r = ZMIN64[ZW-1:0];
    end else begin
      r = v[ZW-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/mec_front.sv
// Front end: configuration registers, input acceptance and classification.
// Depends on mec_pkg; feeds entries to mec_fifo.
module mec_front #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic signed [mec_pkg::ZW-1:0]       c_real,
  input  logic signed [mec_pkg::ZW-1:0]       c_imag,
  input  logic                                q_full,
  output logic                                q_push,
  output mec_pkg::entry_t                     q_entry,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mec_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [mec_pkg::MAG_WIDTH-1:0]       thr
);
  import mec_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > MAXIT_WIDTH) ? COUNT_WIDTH : MAXIT_WIDTH;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [MAG_WIDTH-1:0] THR_RESET = MAG_WIDTH'(64'd4 << FRAC_BITS);

  logic [MAXIT_WIDTH-1:0] max_iterations;
  logic [MAG_WIDTH-1:0]   escape_threshold;
  logic [CMP_W-1:0]       limit_wide;
  logic [CMP_W-1:0]       limit_cap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations   <= MAXIT_RESET;
      escape_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_ITER:  max_iterations   <= cfg_data[MAXIT_WIDTH-1:0];
        CFG_THRESHOLD: escape_threshold <= cfg_data[MAG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The limit is clipped so that the count always fits the result port.
  assign limit_wide = CMP_W'(max_iterations);
  assign limit_cap  = (limit_wide > COUNT_MAX) ? COUNT_MAX : limit_wide;

  assign q_push          = push && !q_full;
  assign q_entry.c_real  = c_real;
  assign q_entry.c_imag  = c_imag;
  assign q_entry.limit   = limit_cap[MAXIT_WIDTH-1:0];
  assign q_entry.trivial = (limit_cap == '0);
  assign thr             = escape_threshold;

endmodule

// File: src/mec_fifo.sv
// Short queue of classified points between the front and back ends.
// Depends on mec_pkg for the entry type and depth.
module mec_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mec_pkg::entry_t wr_data,
  output logic            full,
  output logic            rd_valid,
  input  logic            rd_en,
  output mec_pkg::entry_t rd_data
);
  import mec_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full     = (fill == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: src/mec_back.sv
// Back end: the iteration engine and the result register.
// Depends on mec_pkg; takes entries from mec_fifo.
module mec_back #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  mec_pkg::entry_t               q_entry,
  output logic                          q_take,
  input  logic [mec_pkg::MAG_WIDTH-1:0] thr,
  output logic                          empty,
  input  logic                          pop,
  output logic [COUNT_WIDTH-1:0]        iteration_count
);
  import mec_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > MAXIT_WIDTH) ? COUNT_WIDTH : MAXIT_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_UPD, S_DONE} state_t;

  state_t               state;
  logic signed [ZW-1:0] zr, zi, cr, ci;
  logic [CMP_W-1:0]     limit;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] result;
  logic                 out_valid;
  logic [63:0]          pr, pi;
  logic signed [63:0]   px;

  logic [ZW-1:0]        ar, ai;
  logic [63:0]          x2, y2;
  logic [MAG_WIDTH:0]   mag;
  logic                 at_limit, stop, out_load;
  logic signed [NR_W-1:0] nr;
  logic signed [63:0]   ni;
  logic signed [ZW-1:0] zr_next, zi_next;

  assign ar = zr[ZW-1] ? (~zr + 1'b1) : zr;
  assign ai = zi[ZW-1] ? (~zi + 1'b1) : zi;

  assign x2  = pr >> FRAC_BITS;
  assign y2  = pi >> FRAC_BITS;
  assign mag = {1'b0, x2[MAG_WIDTH-1:0]} + {1'b0, y2[MAG_WIDTH-1:0]};

  assign at_limit = (CMP_W'(count) == limit);
  assign stop = at_limit || (x2 > MAG_MAX) || (y2 > MAG_MAX) ||
                (mag > {1'b0, thr});

  // Both squares are known to fit the magnitude width when these are used.
  assign nr = $signed({2'b00, x2[MAG_WIDTH-1:0]}) - $signed({2'b00, y2[MAG_WIDTH-1:0]})
              + $signed({{(NR_W-ZW){cr[ZW-1]}}, cr});
  assign ni = (px >>> (FRAC_BITS - 1)) + $signed({{(64-ZW){ci[ZW-1]}}, ci});
  assign zr_next = sat_z($signed({{(64-NR_W){nr[NR_W-1]}}, nr}));
  assign zi_next = sat_z(ni);

  assign q_take   = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_DONE) && (!out_valid || pop);
  assign empty    = !out_valid;
  assign iteration_count = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cr    <= q_entry.c_real;
            ci    <= q_entry.c_imag;
            limit <= CMP_W'(q_entry.limit);
            zr    <= '0;
            zi    <= '0;
            count <= '0;
            state <= q_entry.trivial ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          pr    <= ar * ar;
          pi    <= ai * ai;
          px    <= zr * zi;
          state <= S_UPD;
        end
        S_UPD: begin
          if (stop) begin
            state <= S_DONE;
          end else begin
            count <= count + 1'b1;
            zr    <= zr_next;
            zi    <= zi_next;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_load) begin
            result <= count;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (CMP_W'(count) <= limit))
    else $error("iteration count ran past its limit");

  a_mul_then_upd: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_UPD))
    else $error("product stage not followed by update");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (CMP_W'(result) <= limit)))
    else $error("result word lost or above limit");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |=> (state != S_IDLE))
    else $error("engine stayed idle after taking a point");
`endif

endmodule

// File: src/mandelbrot_escape_count_core.sv
// The back end works on one point at a time in a square-and-update loop: a
// multiply state (S_MUL), then an add, compare and saturate state (S_UPD); the
// queue in front of it can take new points meanwhile. A zero limit skips the loop.
// Reset (rst, synchronous, active high) empties the queue and result register and
// restores max_iterations to 128 and escape_threshold to 4.0.
module mandelbrot_escape_count_core #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [mec_pkg::ZW-1:0]  c_real,
  input  logic signed [mec_pkg::ZW-1:0]  c_imag,
  output logic                           empty,
  input  logic                           pop,
  output logic [COUNT_WIDTH-1:0]         iteration_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mec_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mec_pkg::*;

  // The front end holds the configuration, clips the iteration limit to the
  // width of the result and marks points whose limit is zero so that the
  // engine can report them without iterating.
  logic                 q_full;
  logic                 q_push;
  entry_t               q_wr_entry;
  logic                 q_valid;
  logic                 q_take;
  entry_t               q_rd_entry;
  logic [MAG_WIDTH-1:0] thr;

  mec_front #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .c_real    (c_real),
    .c_imag    (c_imag),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // The queue lets new points be accepted while the engine is still
  // iterating on an earlier one.
  mec_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_entry),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_data  (q_rd_entry)
  );

  // The back end iterates z = z*z + c and holds each finished count in a
  // result register until it is popped, whilst it may already fetch the
  // next point.
  mec_back #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (q_rd_entry),
    .q_take          (q_take),
    .thr             (thr),
    .empty           (empty),
    .pop             (pop),
    .iteration_count (iteration_count)
  );

  assign full = q_full;

endmodule
